### design/gtpu_pkg.sv
package gtpu_pkg;

    // Frame classes, decided when the IPv4 header completes
    localparam logic [1:0] CLASS_UNDECIDED = 2'd0;
    localparam logic [1:0] CLASS_UPLINK    = 2'd1;
    localparam logic [1:0] CLASS_DOWNLINK  = 2'd2;
    localparam logic [1:0] CLASS_DROPPED   = 2'd3;

    // Result kinds carried on tuser
    localparam logic [1:0] KIND_UPLINK   = 2'd0;
    localparam logic [1:0] KIND_DOWNLINK = 2'd1;
    localparam logic [1:0] KIND_MARKER   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_MATCH_SRC = 3'd0;
    localparam logic [2:0] CFG_NEW_SRC   = 3'd1;
    localparam logic [2:0] CFG_NEW_DST   = 3'd2;
    localparam logic [2:0] CFG_NEW_PORT  = 3'd3;
    localparam logic [2:0] CFG_TEID      = 3'd4;
    localparam logic [2:0] CFG_FLAGS     = 3'd5;
    localparam logic [2:0] CFG_MSG_TYPE  = 3'd6;

    // Frame layout
    localparam logic [15:0] VLAN_TYPE   = 16'h8100;
    localparam logic [15:0] ETH_LEN     = 16'd14;
    localparam logic [15:0] VLAN_LEN    = 16'd18;
    localparam logic [15:0] POS_TYPE_HI = 16'd12;
    localparam logic [15:0] POS_TYPE_LO = 16'd13;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam logic [15:0] IP_LEN      = 16'd20;
    localparam logic [15:0] OFF_PROTO   = 16'd9;
    localparam logic [15:0] OFF_SRC0    = 16'd12;
    localparam logic [15:0] OFF_SRC3    = 16'd15;
    localparam logic [15:0] OFF_IP_LAST = 16'd19;
    localparam logic [15:0] OFF_PORT_HI = 16'd22;
    localparam logic [15:0] OFF_PORT_LO = 16'd23;
    localparam logic [15:0] OFF_CSUM_HI = 16'd26;
    localparam logic [15:0] OFF_CSUM_LO = 16'd27;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;

    // Header burst: GTP-U header then rewritten IPv4 header
    localparam int          BURST_LEN  = 28;
    localparam int          IDX_W      = 5;
    localparam logic [4:0]  IDX_IP0    = 5'd8;
    localparam logic [4:0]  IDX_IPCS   = 5'd18;
    localparam logic [4:0]  IDX_LAST   = 5'(BURST_LEN - 1);
    localparam int          HDR_DEPTH  = 20;
    localparam int          HDR_AW     = 5;

    typedef struct packed {
        logic [31:0] match_src;
        logic [31:0] new_src;
        logic [31:0] new_dst;
        logic [15:0] new_port;
        logic [31:0] teid;
        logic [7:0]  flags;
        logic [7:0]  msg_type;
    } cfg_t;

    typedef struct packed {
        logic [15:0] port;
        logic [1:0]  kind;
        logic        last;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic burst_active;
        logic burst_start;
    } eng_status_t;

endpackage

### design/gtpu_out_fifo.sv
module gtpu_out_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gtpu_pkg::item_t    push_item,
    output logic               space,
    output logic [1:0]         count,
    output logic               m_valid,
    output gtpu_pkg::item_t    m_item,
    input  logic               m_ready
);

    gtpu_pkg::item_t slot_reg [2];
    logic            head_reg, head_next;
    logic            tail_reg, tail_next;
    logic [1:0]      count_reg, count_next;
    logic            pop;

    assign pop     = (count_reg != 2'd0) && m_ready;
    assign space   = (count_reg != 2'd2);
    assign count   = count_reg;
    assign m_valid = (count_reg != 2'd0);
    assign m_item  = slot_reg[head_reg];

    // Advance pointers and occupancy
    always_comb begin
        head_next  = pop ? ~head_reg : head_reg;
        tail_next  = push ? ~tail_reg : tail_reg;
        count_next = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store item
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[tail_reg] <= push_item;
        end
    end

endmodule

### design/gtpu_engine.sv
module gtpu_engine (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gtpu_pkg::cfg_t          cfg,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              in_byte,
    input  logic                    in_last,
    input  logic [15:0]             frame_len,
    output logic                    push,
    output gtpu_pkg::item_t         push_item,
    input  logic                    space,
    output gtpu_pkg::eng_status_t   status
);

    // IPv4 header memory, registered read
    logic [7:0] hdr_mem [gtpu_pkg::HDR_DEPTH];
    logic [7:0] rd_data_reg;
    logic [gtpu_pkg::HDR_AW-1:0] rd_addr;
    logic       mem_we;

    // Per-frame state
    logic [15:0] pos_reg, pos_next;
    logic        vlan_reg, vlan_next;
    logic [7:0]  type_hi_reg, type_hi_next;
    logic [1:0]  class_reg, class_next;
    logic [15:0] flen_reg, flen_next;
    logic [19:0] acc_reg, acc_next;
    logic [31:0] src_reg, src_next;
    logic [7:0]  proto_reg, proto_next;
    logic        emitted_reg, emitted_next;
    logic [15:0] port_reg, port_next;
    logic [7:0]  port_hi_reg, port_hi_next;

    // Burst sequencer
    logic                     burst_reg, burst_next;
    logic [gtpu_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                     blast_reg, blast_next;
    logic [19:0]              sum_reg, sum_next;
    logic [15:0]              len_reg, len_next;

    logic        s_fire, vlan_now, burst_start, burst_push;
    logic [15:0] hdr_len, off;
    logic        single_push;
    gtpu_pkg::item_t single_item, burst_item;
    logic [16:0] fold1;
    logic [15:0] fold2, csum;

    assign s_ready     = !burst_reg && space;
    assign s_fire      = s_valid && s_ready;
    assign burst_push  = burst_reg && space;
    assign status.burst_active = burst_reg;
    assign status.burst_start  = burst_start;

    // Parse one input item
    always_comb begin
        pos_next     = pos_reg;
        vlan_next    = vlan_reg;
        type_hi_next = type_hi_reg;
        class_next   = class_reg;
        flen_next    = flen_reg;
        acc_next     = acc_reg;
        src_next     = src_reg;
        proto_next   = proto_reg;
        emitted_next = emitted_reg;
        port_next    = port_reg;
        port_hi_next = port_hi_reg;
        mem_we       = 1'b0;
        burst_start  = 1'b0;
        single_push  = 1'b0;
        single_item  = '0;
        vlan_now     = vlan_reg;
        if (pos_reg == gtpu_pkg::POS_TYPE_LO) begin
            vlan_now = ({type_hi_reg, in_byte} == gtpu_pkg::VLAN_TYPE);
        end
        hdr_len = vlan_now ? gtpu_pkg::VLAN_LEN : gtpu_pkg::ETH_LEN;
        off     = pos_reg - hdr_len;
        if (s_fire) begin
            if (pos_reg == 16'd0) flen_next = frame_len;
            if (pos_reg == gtpu_pkg::POS_TYPE_HI) type_hi_next = in_byte;
            vlan_next = vlan_now;
            if (pos_reg >= hdr_len) begin
                if (off < gtpu_pkg::IP_LEN) begin
                    mem_we = 1'b1;
                    // Running sum of header words ahead of the checksum field
                    if (off == 16'd0) begin
                        acc_next = {4'd0, in_byte, 8'd0};
                    end else if (off <= gtpu_pkg::OFF_PROTO) begin
                        acc_next = acc_reg + (off[0] ? 20'(in_byte) : 20'({in_byte, 8'd0}));
                    end
                    if (off == gtpu_pkg::OFF_PROTO) proto_next = in_byte;
                    if (off >= gtpu_pkg::OFF_SRC0 && off <= gtpu_pkg::OFF_SRC3) begin
                        src_next = {src_reg[23:0], in_byte};
                    end
                    if (off == gtpu_pkg::OFF_IP_LAST) begin
                        if (src_reg == cfg.match_src) begin
                            if (proto_reg == gtpu_pkg::PROTO_UDP) begin
                                class_next  = gtpu_pkg::CLASS_UPLINK;
                                burst_start = 1'b1;
                            end else begin
                                class_next       = gtpu_pkg::CLASS_DROPPED;
                                single_push      = 1'b1;
                                single_item.kind = gtpu_pkg::KIND_MARKER;
                            end
                        end else begin
                            class_next = gtpu_pkg::CLASS_DOWNLINK;
                        end
                    end
                end else if (class_reg == gtpu_pkg::CLASS_UPLINK) begin
                    single_push      = 1'b1;
                    single_item.kind = gtpu_pkg::KIND_UPLINK;
                    priority if (off == gtpu_pkg::OFF_PORT_HI) begin
                        single_item.data = cfg.new_port[15:8];
                    end else if (off == gtpu_pkg::OFF_PORT_LO) begin
                        single_item.data = cfg.new_port[7:0];
                    end else if (off == gtpu_pkg::OFF_CSUM_HI
                                 || off == gtpu_pkg::OFF_CSUM_LO) begin
                        single_item.data = 8'd0;
                    end else begin
                        single_item.data = in_byte;
                    end
                end else if (class_reg == gtpu_pkg::CLASS_DOWNLINK) begin
                    // Learn the destination port
                    if (off == gtpu_pkg::OFF_PORT_HI) port_hi_next = in_byte;
                    if (off == gtpu_pkg::OFF_PORT_LO) port_next = {port_hi_reg, in_byte};
                    single_push      = 1'b1;
                    single_item.kind = gtpu_pkg::KIND_DOWNLINK;
                    single_item.data = in_byte;
                end
            end
            if (single_push || burst_start) emitted_next = 1'b1;
            // Close the frame
            if (in_last) begin
                if (single_push) begin
                    single_item.last = 1'b1;
                end else if (!burst_start && !emitted_reg) begin
                    single_push      = 1'b1;
                    single_item.kind = gtpu_pkg::KIND_MARKER;
                    single_item.last = 1'b1;
                end
                pos_next     = 16'd0;
                vlan_next    = 1'b0;
                class_next   = gtpu_pkg::CLASS_UNDECIDED;
                emitted_next = 1'b0;
            end else if (pos_reg != gtpu_pkg::POS_MAX) begin
                pos_next = pos_reg + 16'd1;
            end
            if (class_next == gtpu_pkg::CLASS_DROPPED) single_item.last = 1'b1;
        end
        single_item.port = port_next;
    end

    // Sequence the header burst
    always_comb begin
        burst_next = burst_reg;
        idx_next   = idx_reg;
        blast_next = blast_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        if (burst_start) begin
            burst_next = 1'b1;
            idx_next   = '0;
            blast_next = in_last;
            sum_next   = acc_reg + 20'(cfg.new_src[31:16]) + 20'(cfg.new_src[15:0])
                       + 20'(cfg.new_dst[31:16]) + 20'(cfg.new_dst[15:0]);
            len_next   = (flen_reg >= hdr_len) ? flen_reg - hdr_len : 16'd0;
        end else if (burst_push) begin
            idx_next = idx_reg + 1'b1;
            if (idx_reg == gtpu_pkg::IDX_LAST) burst_next = 1'b0;
        end
        if (idx_next >= gtpu_pkg::IDX_IP0 && idx_next < gtpu_pkg::IDX_IPCS) begin
            rd_addr = idx_next - gtpu_pkg::IDX_IP0;
        end else begin
            rd_addr = '0;
        end
    end

    // Fold the header checksum
    always_comb begin
        fold1 = 17'(sum_reg[19:16]) + 17'(sum_reg[15:0]);
        fold2 = fold1[15:0] + 16'(fold1[16]);
        csum  = ~fold2;
    end

    // Select the burst byte
    always_comb begin
        burst_item      = '0;
        burst_item.kind = gtpu_pkg::KIND_UPLINK;
        burst_item.port = port_reg;
        burst_item.last = blast_reg && (idx_reg == gtpu_pkg::IDX_LAST);
        case (idx_reg)
            5'd0:  burst_item.data = cfg.flags;
            5'd1:  burst_item.data = cfg.msg_type;
            5'd2:  burst_item.data = len_reg[15:8];
            5'd3:  burst_item.data = len_reg[7:0];
            5'd4:  burst_item.data = cfg.teid[31:24];
            5'd5:  burst_item.data = cfg.teid[23:16];
            5'd6:  burst_item.data = cfg.teid[15:8];
            5'd7:  burst_item.data = cfg.teid[7:0];
            5'd18: burst_item.data = csum[15:8];
            5'd19: burst_item.data = csum[7:0];
            5'd20: burst_item.data = cfg.new_src[31:24];
            5'd21: burst_item.data = cfg.new_src[23:16];
            5'd22: burst_item.data = cfg.new_src[15:8];
            5'd23: burst_item.data = cfg.new_src[7:0];
            5'd24: burst_item.data = cfg.new_dst[31:24];
            5'd25: burst_item.data = cfg.new_dst[23:16];
            5'd26: burst_item.data = cfg.new_dst[15:8];
            5'd27: burst_item.data = cfg.new_dst[7:0];
            default: burst_item.data = rd_data_reg;
        endcase
    end

    assign push      = single_push || burst_push;
    assign push_item = burst_reg ? burst_item : single_item;

    // Header memory: the burst reads entries written by this frame's header
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hdr_mem[off[gtpu_pkg::HDR_AW-1:0]] <= in_byte;
        end
        rd_data_reg <= hdr_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            vlan_reg    <= 1'b0;
            type_hi_reg <= '0;
            class_reg   <= gtpu_pkg::CLASS_UNDECIDED;
            flen_reg    <= '0;
            acc_reg     <= '0;
            emitted_reg <= 1'b0;
            port_reg    <= '0;
            port_hi_reg <= '0;
            burst_reg   <= 1'b0;
            idx_reg     <= '0;
            blast_reg   <= 1'b0;
        end else begin
            pos_reg     <= pos_next;
            vlan_reg    <= vlan_next;
            type_hi_reg <= type_hi_next;
            class_reg   <= class_next;
            flen_reg    <= flen_next;
            acc_reg     <= acc_next;
            emitted_reg <= emitted_next;
            port_reg    <= port_next;
            port_hi_reg <= port_hi_next;
            burst_reg   <= burst_next;
            idx_reg     <= idx_next;
            blast_reg   <= blast_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        src_reg   <= src_next;
        proto_reg <= proto_next;
        sum_reg   <= sum_next;
        len_reg   <= len_next;
    end

endmodule

### design/gtpu_encap_ip_rewrite_unit.sv
// GTP-U encapsulation with IPv4 header rewrite.
// s_ channel: one Ethernet frame byte per item, tlast on the final byte,
// frame length in tdata sampled on the frame's first byte.
// m_ channel: stripped or encapsulated packet bytes; tuser gives the kind
// (uplink byte, downlink byte, drop marker), tlast ends each frame's output.
// cfg channel: register writes by index, always ready; write only when idle.
// Throughput: one byte per cycle while the output queue has space. When the
// IPv4 header of an uplink UDP frame completes, the header sequencer emits 28
// bytes (GTP-U header plus rewritten IPv4 header), one per cycle while there
// is space, and holds s_tready low until it ends. A result enters the
// two-entry output queue in the cycle its byte is accepted and shows on m_
// in the cycle after. IPv4 header bytes come from a 20-entry memory with a
// registered read. Reset clears frame position, class, learned port and the
// output queue and loads the default addresses, port and tunnel fields.
// When the receiver stalls, the queue fills and s_tready drops; no item is
// lost or repeated.
module gtpu_encap_ip_rewrite_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // in_byte[7:0], frame_len[23:8]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_byte[7:0], learned_port[23:8]
    output logic        m_tlast,
    output logic [1:0]  m_tuser,    // out_kind[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    gtpu_pkg::cfg_t        cfg_reg;
    gtpu_pkg::item_t       push_item, out_item;
    gtpu_pkg::eng_status_t status;
    logic                  push, space;
    logic [1:0]            q_count;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.match_src <= 32'd352321550;
            cfg_reg.new_src   <= 32'd564920321;
            cfg_reg.new_dst   <= 32'd170417410;
            cfg_reg.new_port  <= 16'd23016;
            cfg_reg.teid      <= 32'd268435457;
            cfg_reg.flags     <= 8'h30;
            cfg_reg.msg_type  <= 8'hFF;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                gtpu_pkg::CFG_MATCH_SRC: cfg_reg.match_src <= cfg_data;
                gtpu_pkg::CFG_NEW_SRC:   cfg_reg.new_src   <= cfg_data;
                gtpu_pkg::CFG_NEW_DST:   cfg_reg.new_dst   <= cfg_data;
                gtpu_pkg::CFG_NEW_PORT:  cfg_reg.new_port  <= cfg_data[15:0];
                gtpu_pkg::CFG_TEID:      cfg_reg.teid      <= cfg_data;
                gtpu_pkg::CFG_FLAGS:     cfg_reg.flags     <= cfg_data[7:0];
                gtpu_pkg::CFG_MSG_TYPE:  cfg_reg.msg_type  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    gtpu_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .in_byte   (s_tdata[7:0]),
        .in_last   (s_tlast),
        .frame_len (s_tdata[23:8]),
        .push      (push),
        .push_item (push_item),
        .space     (space),
        .status    (status)
    );

    gtpu_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .space     (space),
        .count     (q_count),
        .m_valid   (m_tvalid),
        .m_item    (out_item),
        .m_ready   (m_tready)
    );

    assign m_tdata = {out_item.port, out_item.data};
    assign m_tlast = out_item.last;
    assign m_tuser = out_item.kind;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count != 2'd3)
        else $error("output queue overfilled");

    a_burst_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        status.burst_active |-> !s_tready)
        else $error("input accepted during header burst");

    a_burst_follows_start: assert property (@(posedge aclk) disable iff (!aresetn)
        status.burst_start |=> status.burst_active)
        else $error("header burst did not begin");

    a_kind_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != gtpu_pkg::KIND_RESERVED)
        else $error("reserved result kind");

endmodule

### test/tb_gtpu_encap_ip_rewrite_unit.sv
module tb_gtpu_encap_ip_rewrite_unit;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;      // in_byte[7:0], frame_len[23:8]
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // out_byte[7:0], learned_port[23:8]
    logic        m_tlast;
    logic [1:0]  m_tuser;           // out_kind[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    gtpu_encap_ip_rewrite_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 aclk = ~aclk;

    // predictor state
    gtpu_pkg::cfg_t  regs;
    logic [15:0]     pos_q;
    logic            vlan_q;
    logic [7:0]      hdr_mem [20];
    logic [1:0]      class_q;
    logic [15:0]     flen_q;
    logic [15:0]     port_q;
    logic [7:0]      type_hi_q;
    logic [7:0]      port_hi_q;
    logic            any_out_q;

    gtpu_pkg::item_t expected_q[$];
    int              mismatches = 0;
    int              burst_max = 3;
    int              gap_max = 3;
    int              stall_pct = 30;

    // append one predicted result
    task automatic push_result(input logic [7:0] b, input logic [1:0] k, input logic l);
        gtpu_pkg::item_t it;
        it.data = b;
        it.last = l;
        it.kind = k;
        it.port = port_q;
        expected_q.push_back(it);
        any_out_q = 1'b1;
    endtask

    task automatic clear_model();
        regs = '{32'd352321550, 32'd564920321, 32'd170417410, 16'd23016,
                 32'd268435457, 8'h30, 8'hFF};
        pos_q = '0; vlan_q = 1'b0; class_q = gtpu_pkg::CLASS_UNDECIDED; flen_q = '0;
        port_q = '0; type_hi_q = '0; port_hi_q = '0; any_out_q = 1'b0;
    endtask

    // GTP-U header plus rewritten IPv4 header
    task automatic predict_burst(input logic [15:0] hl);
        logic [7:0]  h [20];
        logic [19:0] acc;
        logic [16:0] fold;
        logic [15:0] csum, glen;
        h = hdr_mem;
        for (int i = 0; i < 4; i++) begin
            h[12+i] = regs.new_src[31-8*i -: 8];
            h[16+i] = regs.new_dst[31-8*i -: 8];
        end
        h[10] = 8'd0; h[11] = 8'd0;
        acc = '0;
        for (int i = 0; i < 10; i++) acc += 20'({h[2*i], h[2*i+1]});
        fold = 17'(acc[19:16]) + 17'(acc[15:0]);
        fold = fold + 17'(fold[16]);
        csum = ~fold[15:0];
        h[10] = csum[15:8]; h[11] = csum[7:0];
        glen = (flen_q >= hl) ? flen_q - hl : 16'd0;
        push_result(regs.flags, gtpu_pkg::KIND_UPLINK, 1'b0);
        push_result(regs.msg_type, gtpu_pkg::KIND_UPLINK, 1'b0);
        push_result(glen[15:8], gtpu_pkg::KIND_UPLINK, 1'b0);
        push_result(glen[7:0], gtpu_pkg::KIND_UPLINK, 1'b0);
        for (int i = 0; i < 4; i++)
            push_result(regs.teid[31-8*i -: 8], gtpu_pkg::KIND_UPLINK, 1'b0);
        for (int i = 0; i < 20; i++) push_result(h[i], gtpu_pkg::KIND_UPLINK, 1'b0);
    endtask

    // advance the predictor by one frame byte
    task automatic predict_byte(input logic [7:0] b, input logic l, input logic [15:0] fl);
        int          n0;
        logic [15:0] hl, off;
        logic [7:0]  ob;
        n0 = expected_q.size();
        if (pos_q == 16'd0) flen_q = fl;
        if (pos_q == gtpu_pkg::POS_TYPE_HI) type_hi_q = b;
        if (pos_q == gtpu_pkg::POS_TYPE_LO) vlan_q = ({type_hi_q, b} == gtpu_pkg::VLAN_TYPE);
        hl = vlan_q ? gtpu_pkg::VLAN_LEN : gtpu_pkg::ETH_LEN;
        if (pos_q >= hl) begin
            off = pos_q - hl;
            if (off < gtpu_pkg::IP_LEN) begin
                hdr_mem[off] = b;
                if (off == gtpu_pkg::OFF_IP_LAST) begin
                    if ({hdr_mem[12], hdr_mem[13], hdr_mem[14], hdr_mem[15]} ==
                        regs.match_src) begin
                        if (hdr_mem[gtpu_pkg::OFF_PROTO] == gtpu_pkg::PROTO_UDP) begin
                            class_q = gtpu_pkg::CLASS_UPLINK;
                            predict_burst(hl);
                        end else begin
                            class_q = gtpu_pkg::CLASS_DROPPED;
                            push_result(8'd0, gtpu_pkg::KIND_MARKER, 1'b1);
                        end
                    end else class_q = gtpu_pkg::CLASS_DOWNLINK;
                end
            end else if (class_q == gtpu_pkg::CLASS_UPLINK) begin
                ob = b;
                if (off == gtpu_pkg::OFF_PORT_HI) ob = regs.new_port[15:8];
                else if (off == gtpu_pkg::OFF_PORT_LO) ob = regs.new_port[7:0];
                else if (off == gtpu_pkg::OFF_CSUM_HI || off == gtpu_pkg::OFF_CSUM_LO)
                    ob = 8'd0;
                push_result(ob, gtpu_pkg::KIND_UPLINK, 1'b0);
            end else if (class_q == gtpu_pkg::CLASS_DOWNLINK) begin
                if (off == gtpu_pkg::OFF_PORT_HI) port_hi_q = b;
                if (off == gtpu_pkg::OFF_PORT_LO) port_q = {port_hi_q, b};
                push_result(b, gtpu_pkg::KIND_DOWNLINK, 1'b0);
            end
        end
        if (l) begin
            if (expected_q.size() > n0) expected_q[$].last = 1'b1;
            else if (!any_out_q) push_result(8'd0, gtpu_pkg::KIND_MARKER, 1'b1);
            pos_q = '0; vlan_q = 1'b0; class_q = gtpu_pkg::CLASS_UNDECIDED; any_out_q = 1'b0;
        end else if (pos_q != gtpu_pkg::POS_MAX) pos_q = pos_q + 16'd1;
    endtask

    // send one byte, honoring the burst/gap pattern
    int burst_left = 0;
    task automatic send_byte(input logic [7:0] b, input logic l, input logic [15:0] fl);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        predict_byte(b, l, fl);
        s_tvalid <= 1'b1;
        s_tdata  <= {fl, b};
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            gtpu_pkg::CFG_MATCH_SRC: regs.match_src = v;
            gtpu_pkg::CFG_NEW_SRC:   regs.new_src = v;
            gtpu_pkg::CFG_NEW_DST:   regs.new_dst = v;
            gtpu_pkg::CFG_NEW_PORT:  regs.new_port = v[15:0];
            gtpu_pkg::CFG_TEID:      regs.teid = v;
            gtpu_pkg::CFG_FLAGS:     regs.flags = v[7:0];
            gtpu_pkg::CFG_MSG_TYPE:  regs.msg_type = v[7:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // build and send one frame; src selects uplink match
    task automatic send_frame(input bit vlan, input bit up, input logic [7:0] proto,
                              input int payload, input logic [15:0] fl, input int cut);
        logic [7:0] fr [$];
        logic [31:0] src;
        for (int i = 0; i < 12; i++) fr.push_back(8'($urandom_range(0, 255)));
        if (vlan) begin
            fr.push_back(8'h81); fr.push_back(8'h00);
            fr.push_back(8'($urandom_range(0, 255))); fr.push_back(8'($urandom_range(0, 255)));
        end
        fr.push_back(8'h08); fr.push_back(8'h00);
        src = up ? regs.match_src : $urandom;
        if (!up && src == regs.match_src) src = ~src;
        for (int i = 0; i < 20; i++) begin
            if (i == 9) fr.push_back(proto);
            else if (i >= 12 && i < 16) fr.push_back(src[31-8*(i-12) -: 8]);
            else fr.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < payload; i++) fr.push_back(8'($urandom_range(0, 255)));
        if (cut > 0 && cut < fr.size()) fr = fr[0:cut-1];
        foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1, fl);
    endtask

    // check each accepted result against the oldest expectation
    always @(posedge aclk) begin
        gtpu_pkg::item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: data %h last %b kind %h port %h",
                             m_tdata[7:0], m_tlast, m_tuser, m_tdata[23:8]);
            end else begin
                want = expected_q.pop_front();
                if (want.data !== m_tdata[7:0] || want.last !== m_tlast ||
                    want.kind !== m_tuser || want.port !== m_tdata[23:8]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp data %h last %b kind %h port %h, got %h %b %h %h",
                                 want.data, want.last, want.kind, want.port,
                                 m_tdata[7:0], m_tlast, m_tuser, m_tdata[23:8]);
                end
            end
        end
    end

    // receiver stall pattern: runs of ready and not ready
    int stall_run = 0;
    always @(posedge aclk) begin
        if (stall_run > 0) stall_run <= stall_run - 1;
        else begin
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
            stall_run <= $urandom_range(0, 6);
        end
    end

    task automatic test_directed();
        send_frame(1'b0, 1'b1, gtpu_pkg::PROTO_UDP, 8, 16'd64, 0);   // port and csum rewrite
        send_frame(1'b0, 1'b0, 8'd6, 4, 16'd60, 0);                 // downlink learns port
        send_frame(1'b0, 1'b1, 8'd6, 0, 16'd0, 0);                  // uplink TCP dropped
        send_frame(1'b0, 1'b0, 8'd0, 0, 16'd20, 20);                // ends in IP header
        send_byte(8'hFF, 1'b1, 16'hFFFF);                           // one-byte frame
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_reg(gtpu_pkg::CFG_MATCH_SRC, 32'hFFFF_FFFF);
        write_reg(gtpu_pkg::CFG_NEW_SRC, 32'h0);
        write_reg(gtpu_pkg::CFG_NEW_DST, 32'hFFFF_FFFF);
        write_reg(gtpu_pkg::CFG_NEW_PORT, 32'hFFFF);
        write_reg(gtpu_pkg::CFG_TEID, 32'h0);
        write_reg(gtpu_pkg::CFG_FLAGS, 32'hFF);
        write_reg(gtpu_pkg::CFG_MSG_TYPE, 32'h0);
        send_frame(1'b1, 1'b1, gtpu_pkg::PROTO_UDP, 0, 16'd10, 0); // length saturates
        wait_drained();
    endtask

    task automatic test_random_frames();
        bit up;
        for (int phase = 0; phase < 2; phase++) begin
            for (int r = 0; r < 7; r++) write_reg(r[2:0], $urandom);
            burst_max = (phase == 1) ? 60 : 4;
            gap_max = (phase == 1) ? 0 : 4;
            stall_pct = (phase == 1) ? 0 : 40;
            up = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: send_frame(1'($urandom_range(0, 1)), up, 8'($urandom_range(0, 255)),
                              $urandom_range(0, 4), 16'($urandom), $urandom_range(1, 40));
                1: send_frame(1'($urandom_range(0, 1)), up, 8'd6,
                              $urandom_range(0, 4), 16'($urandom), 0);
                default: send_frame(1'($urandom_range(0, 1)), up, gtpu_pkg::PROTO_UDP,
                                    $urandom_range(0, 8), 16'($urandom), 0);
            endcase
            wait_drained();
        end
    endtask

    initial begin
        clear_model();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random_frames();
        if (mismatches == 0 && expected_q.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #400000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
